// File: src/imq_pkg.sv
// ----------------------------------------------------------------------------
// imq_pkg
// shared types and constants for the indexed max-heap priority queue
// ----------------------------------------------------------------------------
package imq_pkg;

  localparam int unsigned CapacityDef      = 256;
  localparam int unsigned PriorityWidthDef = 16;
  localparam int unsigned HandleWidth      = 8;
  localparam int unsigned NumHandles       = 256;
  localparam int unsigned PrioPortWidth    = 16;
  localparam int unsigned StatusWidth      = 3;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_CHANGE  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOTQ   = 3'd3,
    ST_QUEUED = 3'd4
  } status_t;

endpackage

// File: src/indexed_max_priority_queue_top.sv
// an extract from an empty heap or a rejected or ignored item walks no heap
// level; otherwise a sift walks the heap levels through the single read port of
// the heap memory; one item at a time, in_ready low until the result is
// registered
// reset: a clearing pass over the position map after reset, with
// in_ready low; the heap memory is not cleared
// ----------------------------------------------------------------------------
// indexed_max_priority_queue_top
// indexed binary max-heap with handle-to-slot map, sequenced sift unit
// ----------------------------------------------------------------------------
module indexed_max_priority_queue_top #(
  parameter int unsigned CAPACITY       = imq_pkg::CapacityDef,
  parameter int unsigned PRIORITY_WIDTH = imq_pkg::PriorityWidthDef
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_action,
  input  logic [imq_pkg::HandleWidth-1:0]         in_handle,
  input  logic signed [imq_pkg::PrioPortWidth-1:0] in_priority_req,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [imq_pkg::StatusWidth-1:0]         out_status,
  output logic [imq_pkg::HandleWidth-1:0]         out_out_handle,
  output logic signed [imq_pkg::PrioPortWidth-1:0] out_out_priority,
  output logic [8:0]                              out_count
);
  import imq_pkg::*;

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // slot index
  localparam int unsigned CW = $clog2(CAPACITY + 1);                 // count
  localparam int unsigned EW = HandleWidth + PRIORITY_WIDTH;
  localparam int unsigned HMW = $clog2(NumHandles);

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DEC   = 13'b0000000000100,
    S_RDA   = 13'b0000000001000,
    S_UPRD  = 13'b0000000010000,
    S_UPCMP = 13'b0000000100000,
    S_DNRDL = 13'b0000001000000,
    S_DNRDR = 13'b0000010000000,
    S_DNCMP = 13'b0000100000000,
    S_WRMAP = 13'b0001000000000,
    S_TOPRD = 13'b0010000000000,
    S_TOP   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [EW-1:0]  heap_mem [CAPACITY];
  logic [SW:0]    pmap_mem [NumHandles];   // msb queued, low bits slot

  logic [SW-1:0]  hrd_addr;
  logic [EW-1:0]  hrd_data_r;
  logic           hwr_en;
  logic [SW-1:0]  hwr_addr;
  logic [EW-1:0]  hwr_data;
  logic [HMW-1:0] prd_addr;
  logic [SW:0]    prd_data_r;
  logic           pwr_en;
  logic [HMW-1:0] pwr_addr;
  logic [SW:0]    pwr_data;

  always_ff @(posedge clk) begin
    if (hwr_en) begin
      heap_mem[hwr_addr] <= hwr_data;
    end
    hrd_data_r <= heap_mem[hrd_addr];
  end

  always_ff @(posedge clk) begin
    if (pwr_en) begin
      pmap_mem[pwr_addr] <= pwr_data;
    end
    prd_data_r <= pmap_mem[prd_addr];
  end

  // working registers
  logic [1:0]                act_r, act_nxt;
  logic [HandleWidth-1:0]    hdl_r, hdl_nxt;
  logic [PRIORITY_WIDTH-1:0] pri_r, pri_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [SW-1:0]             pos_r, pos_nxt;     // slot of the moving entry
  logic [EW-1:0]             oth_r, oth_nxt;     // parent or best child
  logic [SW-1:0]             opos_r, opos_nxt;
  logic                      hasr_r, hasr_nxt;
  logic [HMW-1:0]            clr_r, clr_nxt;
  logic [2:0]                st_r, st_nxt;
  logic [HandleWidth-1:0]    oh_r, oh_nxt;
  logic [PRIORITY_WIDTH-1:0] op_r, op_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic                      done_up_r, done_up_nxt;  // change: up phase moved

  logic signed [PRIORITY_WIDTH-1:0] cur_p, oth_p, rd_p;
  logic [SW:0]  child_l;
  logic [SW:0]  child_r;
  logic [SW-1:0] parent;

  assign cur_p   = signed'(pri_r);
  assign oth_p   = signed'(oth_r[PRIORITY_WIDTH-1:0]);
  assign rd_p    = signed'(hrd_data_r[PRIORITY_WIDTH-1:0]);
  assign child_l = {pos_r, 1'b1};
  assign child_r = {pos_r, 1'b0} + (SW+1)'(2);
  assign parent  = SW'((pos_r - SW'(1)) >> 1);

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    hdl_nxt    = hdl_r;
    pri_nxt    = pri_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    oth_nxt    = oth_r;
    opos_nxt   = opos_r;
    hasr_nxt   = hasr_r;
    clr_nxt    = clr_r;
    st_nxt     = st_r;
    oh_nxt     = oh_r;
    op_nxt     = op_r;
    ovalid_nxt = ovalid_r;
    done_up_nxt = done_up_r;
    hrd_addr   = '0;
    hwr_en     = 1'b0;
    hwr_addr   = pos_r;
    hwr_data   = {hdl_r, pri_r};
    prd_addr   = hdl_r;
    pwr_en     = 1'b0;
    pwr_addr   = hdl_r;
    pwr_data   = {1'b1, pos_r};
    unique case (state_r)
      S_CLR: begin
        pwr_en   = 1'b1;
        pwr_addr = clr_r;
        pwr_data = '0;
        clr_nxt  = clr_r + HMW'(1);
        if (clr_r == HMW'(NumHandles - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          hdl_nxt   = in_handle;
          pri_nxt   = in_priority_req[PRIORITY_WIDTH-1:0];
          st_nxt    = ST_OK;
          done_up_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end
      // map entry of the handle is being read; root read for extract
      S_DEC: begin
        hrd_addr  = '0;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        // prd_data_r = map of handle, hrd_data_r = root
        hrd_addr = SW'(cnt_r - CW'(1));
        unique case (act_r)
          ACT_INSERT: begin
            if (cnt_r >= CW'(CAPACITY)) begin
              st_nxt = ST_FULL; state_nxt = S_TOPRD;
            end else if (prd_data_r[SW]) begin
              st_nxt = ST_QUEUED; state_nxt = S_TOPRD;
            end else begin
              pos_nxt   = SW'(cnt_r);
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_UPRD;
            end
          end
          ACT_EXTRACT: begin
            if (cnt_r == '0) begin
              st_nxt = ST_EMPTY; oh_nxt = '0; op_nxt = '0; state_nxt = S_OUT;
            end else begin
              oh_nxt = hrd_data_r[EW-1:PRIORITY_WIDTH];
              op_nxt = hrd_data_r[PRIORITY_WIDTH-1:0];
              // unmap extracted handle
              pwr_en   = 1'b1;
              pwr_addr = hrd_data_r[EW-1:PRIORITY_WIDTH];
              pwr_data = '0;
              cnt_nxt  = cnt_r - CW'(1);
              state_nxt = (cnt_r == CW'(1)) ? S_OUT : S_DNRDL;
              pos_nxt  = '0;
            end
          end
          ACT_CHANGE: begin
            if (!prd_data_r[SW] || CW'(prd_data_r[SW-1:0]) >= cnt_r) begin
              st_nxt = ST_NOTQ; state_nxt = S_TOPRD;
            end else begin
              pos_nxt   = prd_data_r[SW-1:0];
              state_nxt = S_UPRD;
            end
          end
          default: state_nxt = S_TOPRD;
        endcase
      end
      S_UPRD: begin
        // root reached ends the climb; a change then tries the way down
        if (pos_r == '0) begin
          state_nxt = S_WRMAP;
          if (act_r == ACT_CHANGE) begin
            state_nxt = S_DNRDL;
          end
        end else begin
          hrd_addr  = parent;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        // wait for the registered read of the parent
        state_nxt = S_UPCMP;
        if (hasr_r) begin
          hasr_nxt = 1'b0;
          if (rd_p < cur_p) begin
            // move parent down into current slot
            hwr_en   = 1'b1;
            hwr_data = hrd_data_r;
            pwr_en   = 1'b1;
            pwr_addr = hrd_data_r[EW-1:PRIORITY_WIDTH];
            pwr_data = {1'b1, pos_r};
            pos_nxt  = parent;
            done_up_nxt = 1'b1;
            state_nxt = S_UPRD;
          end else begin
            state_nxt = (act_r == ACT_CHANGE && !done_up_r) ? S_DNRDL : S_WRMAP;
          end
        end else begin
          hrd_addr = parent;
          hasr_nxt = 1'b1;
        end
      end
      S_DNRDL: begin
        if (act_r == ACT_EXTRACT && hasr_r == 1'b0 && st_r == ST_OK
            && done_up_r == 1'b0) begin
          // fetch last entry as the moving entry
          hrd_addr = SW'(cnt_r);
          hasr_nxt = 1'b1;
          done_up_nxt = 1'b1;
        end else if (act_r == ACT_EXTRACT && hasr_r) begin
          hdl_nxt  = hrd_data_r[EW-1:PRIORITY_WIDTH];
          pri_nxt  = hrd_data_r[PRIORITY_WIDTH-1:0];
          hasr_nxt = 1'b0;
        end else if (child_l >= (SW+1)'(cnt_r)) begin
          state_nxt = S_WRMAP;
        end else begin
          hrd_addr  = SW'(child_l);
          hasr_nxt  = CW'(child_r) < cnt_r;
          state_nxt = S_DNRDR;
        end
      end
      S_DNRDR: begin
        // left child data arrives; issue right read
        hrd_addr = SW'(child_r);
        state_nxt = S_DNCMP;
        oth_nxt  = hrd_data_r;
        opos_nxt = SW'(child_l);
      end
      S_DNCMP: begin
        hasr_nxt = 1'b0;
        if (hasr_r && rd_p > oth_p) begin
          if (rd_p > cur_p) begin
            hwr_en   = 1'b1;
            hwr_data = hrd_data_r;
            pwr_en   = 1'b1;
            pwr_addr = hrd_data_r[EW-1:PRIORITY_WIDTH];
            pwr_data = {1'b1, pos_r};
            pos_nxt  = SW'(child_r);
            state_nxt = S_DNRDL;
          end else begin
            state_nxt = S_WRMAP;
          end
        end else if (oth_p > cur_p) begin
          hwr_en   = 1'b1;
          hwr_data = oth_r;
          pwr_en   = 1'b1;
          pwr_addr = oth_r[EW-1:PRIORITY_WIDTH];
          pwr_data = {1'b1, pos_r};
          pos_nxt  = opos_r;
          state_nxt = S_DNRDL;
        end else begin
          state_nxt = S_WRMAP;
        end
      end
      // place the moving entry at its final slot
      S_WRMAP: begin
        hwr_en    = 1'b1;
        pwr_en    = 1'b1;
        state_nxt = (act_r == ACT_EXTRACT) ? S_OUT : S_TOPRD;
      end
      S_TOPRD: begin
        hrd_addr  = '0;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        if (cnt_r == '0) begin
          oh_nxt = '0; op_nxt = '0;
        end else begin
          oh_nxt = hrd_data_r[EW-1:PRIORITY_WIDTH];
          op_nxt = hrd_data_r[PRIORITY_WIDTH-1:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ovalid_r && out_ready && !(state_r == S_OUT)) begin
      ovalid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      clr_r     <= '0;
      ovalid_r  <= 1'b0;
      hasr_r    <= 1'b0;
      done_up_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      clr_r     <= clr_nxt;
      ovalid_r  <= ovalid_nxt;
      hasr_r    <= hasr_nxt;
      done_up_r <= done_up_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    hdl_r  <= hdl_nxt;
    pri_r  <= pri_nxt;
    pos_r  <= pos_nxt;
    oth_r  <= oth_nxt;
    opos_r <= opos_nxt;
    st_r   <= st_nxt;
    oh_r   <= oh_nxt;
    op_r   <= op_nxt;
  end

  // result holding register: written when the item completes
  logic [StatusWidth-1:0]   rs_st_r;
  logic [HandleWidth-1:0]   rs_h_r;
  logic [PRIORITY_WIDTH-1:0] rs_p_r;
  logic [CW-1:0]            rs_c_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!ovalid_r || out_ready)) begin
      rs_st_r <= st_r;
      rs_h_r  <= oh_r;
      rs_p_r  <= op_r;
      rs_c_r  <= cnt_r;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ovalid_r;
  assign out_status       = rs_st_r;
  assign out_out_handle   = rs_h_r;
  assign out_out_priority = PrioPortWidth'(signed'(rs_p_r));
  assign out_count        = 9'(rs_c_r);

endmodule

// File: src/imq_checker.sv
// ----------------------------------------------------------------------------
// imq_checker
// port-level checks on the priority queue
// ----------------------------------------------------------------------------
module imq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [8:0] out_count
);
  import imq_pkg::*;

  // in_ready is dropped after an accepted transfer, one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

  // result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
    else $error("result dropped");

  // empty status only with zero count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> out_count == 9'd0)
    else $error("empty with entries");

  // full status only with nonzero count
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_count != 9'd0)
    else $error("full with no entries");

endmodule

bind indexed_max_priority_queue_top imq_checker u_imq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_count(out_count)
);

// File: tb/tb_indexed_max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// tb_indexed_max_priority_queue_top
// self-checking bench for the indexed max-heap priority queue: a queue-fed
// driver, a monitor comparing each result with a behavioural heap predictor,
// random idling on both channels and a drain pause in the middle
// ----------------------------------------------------------------------------
module tb_indexed_max_priority_queue_top;
  import imq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         handle;
    logic signed [15:0] prio;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         handle;
    logic signed [15:0] prio;
    logic [8:0]         count;
  } resp_t;

  localparam int Cap = 256;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [7:0] in_handle = '0;
  logic signed [15:0] in_priority_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_out_handle;
  logic signed [15:0] out_out_priority;
  logic [8:0] out_count;

  indexed_max_priority_queue_top DUT (.*);

  // predictor state
  logic [7:0]         hp_handle [Cap];
  logic signed [15:0] hp_prio   [Cap];
  bit                 pm_in     [256];
  int                 pm_slot   [256];
  int                 n_entries;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    n_results = 0;
  int    cycles = 0;
  bit    quiet = 1'b0;      // no idling in the last part
  bit    hold_off = 1'b0;
  int    in_gap = 0, out_gap = 0;
  int    n_sent = 0;
  logic  in_taken = 1'b0;   // input transfer at the last rising edge

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void put_entry(input int s, input logic [7:0] h,
                                    input logic signed [15:0] p);
    hp_handle[s] = h;
    hp_prio[s] = p;
    pm_in[h] = 1'b1;
    pm_slot[h] = s;
  endfunction

  function automatic void swap_slots(input int a, input int b);
    logic [7:0] h;
    logic signed [15:0] p;
    h = hp_handle[a];
    p = hp_prio[a];
    put_entry(a, hp_handle[b], hp_prio[b]);
    put_entry(b, h, p);
  endfunction

  function automatic int bubble_up(input int s);
    int par;
    while (s >= 1) begin
      par = (s - 1) / 2;
      if (!(hp_prio[par] < hp_prio[s])) break;
      swap_slots(par, s);
      s = par;
    end
    return s;
  endfunction

  function automatic void bubble_down(input int s);
    int l, r, b;
    forever begin
      l = 2 * s + 1;
      r = 2 * s + 2;
      b = s;
      if (l < n_entries && hp_prio[l] > hp_prio[b]) b = l;
      if (r < n_entries && hp_prio[r] > hp_prio[b]) b = r;
      if (b == s) break;
      swap_slots(s, b);
      s = b;
    end
  endfunction

  // heap operation on the predictor, returning the expected result
  function automatic resp_t heap_apply(input req_t q);
    resp_t r;
    bit have_top;
    int s;
    r = '0;
    have_top = 1'b0;
    if (q.action == ACT_INSERT) begin
      if (n_entries >= Cap) r.status = ST_FULL;
      else if (pm_in[q.handle]) r.status = ST_QUEUED;
      else begin
        s = n_entries;
        n_entries++;
        put_entry(s, q.handle, q.prio);
        void'(bubble_up(s));
      end
    end else if (q.action == ACT_EXTRACT) begin
      if (n_entries == 0) r.status = ST_EMPTY;
      else begin
        r.handle = hp_handle[0];
        r.prio = hp_prio[0];
        have_top = 1'b1;
        pm_in[hp_handle[0]] = 1'b0;
        pm_slot[hp_handle[0]] = 0;
        n_entries--;
        if (n_entries > 0) begin
          put_entry(0, hp_handle[n_entries], hp_prio[n_entries]);
          bubble_down(0);
        end
      end
    end else if (q.action == ACT_CHANGE) begin
      if (!pm_in[q.handle] || pm_slot[q.handle] >= n_entries) r.status = ST_NOTQ;
      else begin
        s = pm_slot[q.handle];
        hp_prio[s] = q.prio;
        s = bubble_up(s);
        bubble_down(s);
      end
    end
    if (!have_top && n_entries > 0) begin
      r.handle = hp_handle[0];
      r.prio = hp_prio[0];
    end
    r.count = n_entries[8:0];
    return r;
  endfunction

  function automatic req_t mk(input logic [1:0] a, input logic [7:0] h,
                              input logic signed [15:0] p);
    req_t q;
    q.action = a;
    q.handle = h;
    q.prio = p;
    return q;
  endfunction

  // input transfer seen at the rising edge, used by the driver
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) in_gap = quiet ? 0 : (($urandom_range(0, 7) == 0) ?
                                          $urandom_range(1, 11) : 0);
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_off) begin
          in_valid <= 1'b1;
          {in_action, in_handle, in_priority_req} <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (quiet || out_gap == 0) begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 11);
      end else begin
        out_gap--;
        out_ready <= 1'b0;
      end
    end
  end

  // monitor: predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    resp_t got, exp_r;
    cycles++;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_resps.push_back(heap_apply(mk(in_action, in_handle, in_priority_req)));
        n_sent++;
      end
      if (out_valid && out_ready) begin
        got = {out_status, out_out_handle, out_out_priority, out_count};
        n_results++;
        if (expected_resps.size() == 0) begin
          errors++;
          $display("%0t: expected no result, actual %h", $time, got);
        end else begin
          exp_r = expected_resps.pop_front();
          if (got.status !== exp_r.status)
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          if (got.handle !== exp_r.handle)
            $display("%0t: handle expected %0d actual %0d", $time, exp_r.handle, got.handle);
          if (got.prio !== exp_r.prio)
            $display("%0t: priority expected %0d actual %0d", $time, exp_r.prio, got.prio);
          if (got.count !== exp_r.count)
            $display("%0t: count expected %0d actual %0d", $time, exp_r.count, got.count);
          if (got !== exp_r) errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_random(input int n, input int hrange);
    int k;
    logic [1:0] a;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) a = ACT_INSERT;
      else if (k < 75) a = ACT_EXTRACT;
      else if (k < 97) a = ACT_CHANGE;
      else a = 2'd3;
      pending_reqs.push_back(mk(a, 8'($urandom_range(0, hrange)), 16'($urandom)));
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      pm_in[i] = 1'b0;
      pm_slot[i] = 0;
    end
    n_entries = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty, extremes, duplicates, unqueued, unused code, ties
    pending_reqs.push_back(mk(ACT_EXTRACT, 8'd0, 16'sd0));
    pending_reqs.push_back(mk(ACT_CHANGE, 8'd5, 16'sd1));
    pending_reqs.push_back(mk(2'd3, 8'hff, 16'sh7fff));
    pending_reqs.push_back(mk(ACT_INSERT, 8'd0, -16'sd32768));
    pending_reqs.push_back(mk(ACT_INSERT, 8'd255, 16'sd32767));
    pending_reqs.push_back(mk(ACT_INSERT, 8'd255, 16'sd3));
    pending_reqs.push_back(mk(ACT_INSERT, 8'd7, 16'sd32767));
    pending_reqs.push_back(mk(ACT_INSERT, 8'd8, 16'sd32767));
    pending_reqs.push_back(mk(ACT_CHANGE, 8'd0, 16'sd32767));
    pending_reqs.push_back(mk(ACT_CHANGE, 8'd255, -16'sd32768));
    pending_reqs.push_back(mk(2'd3, 8'd1, 16'sd0));
    pending_reqs.push_back(mk(ACT_CHANGE, 8'd9, 16'sd0));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(mk(ACT_EXTRACT, 8'd0, 16'sd0));
    wait_drained();

    // fill to capacity, then full insert, duplicate check order, drain
    for (int i = 0; i < 256; i++) pending_reqs.push_back(mk(ACT_INSERT, 8'(i), 16'($urandom)));
    pending_reqs.push_back(mk(ACT_INSERT, 8'd3, 16'sd0));
    add_random(60, 255);
    // sender pauses mid-stream until every outstanding result has come back
    while (pending_reqs.size() >= 30) @(posedge clk);
    hold_off = 1'b1;
    while (in_valid || expected_resps.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    wait_drained();
    for (int i = 0; i < 100; i++) pending_reqs.push_back(mk(ACT_EXTRACT, 8'd0, 16'sd0));
    wait_drained();

    // random phases, small handle range for frequent hits
    add_random(300, 31);
    add_random(200, 255);
    wait_drained();
    quiet = 1'b1;
    add_random(200, 15);
    wait_drained();
    repeat (60) @(posedge clk);

    $display("covered %0d transfers in, %0d results checked, incl. full and empty heap",
             n_sent, n_results);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
